// File: rtl/assert_macros.svh
// Assertion helpers for the wall column shader.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/rcw_pkg.sv
// ----------------------------------------------------------------------------
// rcw_pkg
// Shared types, constants and helpers of the wall column shader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rcw_pkg;

   localparam int DIV_W     = 38;
   localparam int SPAN_W    = 12;
   localparam int EDGE_W    = 13;
   localparam int TEX_ADR_W = 14;

   localparam logic [11:0] SPAN_MAX   = 12'd2048;
   localparam logic [10:0] ROWS_MAX   = 11'd1024;
   localparam logic [31:0] ROOF_RGBA  = 32'h85803CFF;
   localparam logic [31:0] FLOOR_RGBA = 32'h716221FF;
   localparam logic [31:0] BLACK_RGBA = 32'h000000FF;

   localparam logic [1:0] KIND_COLUMN = 2'd0;
   localparam logic [1:0] KIND_ROW    = 2'd1;
   localparam logic [1:0] KIND_TEXEL  = 2'd2;

   localparam logic [1:0] CSR_HEIGHT = 2'd0;
   localparam logic [1:0] CSR_FOCAL  = 2'd1;
   localparam logic [1:0] CSR_STEP   = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_DEN,
      S_DIV_GO,
      S_DIV,
      S_SPAN,
      S_EDGE,
      S_ROW_CMP,
      S_RDIV_GO,
      S_RDIV,
      S_READ,
      S_SHADE,
      S_OUT
   } state_type;

   // floor(c * 4 / 5) on one byte, via reciprocal multiply.
   function automatic logic [7:0] shade_byte(input logic [7:0] c);
      logic [25:0] p;
      p = {c, 2'b00} * 16'd52429;
      return p[25:18];
   endfunction

   function automatic logic [31:0] shade_rgba(input logic [31:0] c);
      return {shade_byte(c[31:24]), shade_byte(c[23:16]), shade_byte(c[15:8]), c[7:0]};
   endfunction

endpackage
`default_nettype wire

// File: rtl/raycast_wall_column_shader_core.sv
// Column setup: a multiply, the denominator, the 38-step serial divider, the span and
// the strip edges. Row request: a fixed colour above or below the strip or without a
// texture; inside it, 17 divider steps, a texture read and a shade stage. Texel write: on acceptance.
// One item at a time; a finished word waits in the output register while the
// next item is accepted. Synchronous active-high reset clears control state and the
// strip and loads the configuration defaults; the texture store is not cleared.
// ----------------------------------------------------------------------------
// raycast_wall_column_shader_core
// Textured raycaster wall column shader with a bit-serial divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module raycast_wall_column_shader_core
   import rcw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [19:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [15:0] req_hit_distance,
   input  wire logic [15:0] req_view_cosine,
   input  wire logic [5:0]  req_texel_column,
   input  wire logic        req_wall_vertical,
   input  wire logic        req_texture_present,
   input  wire logic [1:0]  req_texture_select,
   input  wire logic [9:0]  req_pixel_row,
   input  wire logic [11:0] req_texel_address,
   input  wire logic [31:0] req_texel_rgba,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_pixel_rgba
);

   state_type state_ff, state_in;

   logic [10:0] height_ff;
   logic [19:0] focal_ff;
   logic [4:0]  step_ff;

   logic [15:0] hd_ff;
   logic [15:0] vc_ff;
   logic [5:0]  tcol_in_ff;
   logic [3:0]  flags_in_ff;
   logic [9:0]  row_ff;
   logic [31:0] perp_ff;
   logic        sat_ff;
   logic [DIV_W-1:0] numer_ff;
   logic [DIV_W-1:0] denom_ff;

   logic [SPAN_W-1:0] span_ff;
   logic signed [EDGE_W-1:0] top_ff;
   logic signed [EDGE_W-1:0] bottom_ff;
   logic [5:0] texel_ff;
   logic [3:0] flags_ff;

   logic [31:0] tex_mem [0:(1 << TEX_ADR_W)-1];
   logic [31:0] rd_data_ff;
   logic [31:0] pix_ff, pix_in;
   logic        pix_load;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;

   logic        accept;
   logic        div_start;
   logic        div_busy;
   logic [DIV_W-1:0] div_numer;
   logic [DIV_W-1:0] div_denom;
   logic [5:0]  div_steps;
   logic [DIV_W-1:0] div_quot;
   logic        load_rsp;
   logic        slot_free;

   logic [4:0]  step_eff;
   logic [36:0] den_prod;
   logic [16:0] span_prod;
   logic [10:0] h_eff;
   logic signed [EDGE_W-1:0] half_s;
   logic signed [EDGE_W-1:0] row_s;
   logic signed [EDGE_W-1:0] off_s;
   logic        in_roof;
   logic        in_floor;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign step_eff  = (step_ff == 5'd0) ? 5'd1 : step_ff;
   assign den_prod  = perp_ff * step_eff;
   assign span_prod = div_quot[11:0] * step_eff;
   assign h_eff     = (height_ff > ROWS_MAX) ? ROWS_MAX : height_ff;
   assign half_s    = EDGE_W'({2'b00, h_eff[10:1]});
   assign row_s     = EDGE_W'({3'b000, row_ff});
   assign off_s     = row_s - top_ff;
   assign in_roof   = row_s < top_ff;
   assign in_floor  = row_s >= bottom_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_kind == KIND_COLUMN) begin
               state_in = S_MUL;
            end else if (accept && req_kind == KIND_ROW) begin
               state_in = S_ROW_CMP;
            end
         end
         S_MUL:    state_in = S_DEN;
         S_DEN:    state_in = S_DIV_GO;
         S_DIV_GO: state_in = S_DIV;
         S_DIV:    state_in = div_busy ? S_DIV : S_SPAN;
         S_SPAN:   state_in = S_EDGE;
         S_EDGE:   state_in = S_IDLE;
         S_ROW_CMP: begin
            if (in_roof || in_floor || !flags_ff[1] || span_ff == '0) begin
               state_in = S_OUT;
            end else begin
               state_in = S_RDIV_GO;
            end
         end
         S_RDIV_GO: state_in = S_RDIV;
         S_RDIV:    state_in = div_busy ? S_RDIV : S_READ;
         S_READ:    state_in = S_SHADE;
         S_SHADE:   state_in = S_OUT;
         S_OUT:     state_in = slot_free ? S_IDLE : S_OUT;
         default:   state_in = S_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      div_numer = numer_ff;
      div_denom = denom_ff;
      div_steps = 6'(DIV_W);
      load_rsp  = 1'b0;
      pix_load  = 1'b0;
      pix_in    = pix_ff;
      case (state_ff)
         S_IDLE:   req_ready = 1'b1;
         S_DIV_GO: div_start = 1'b1;
         S_ROW_CMP: begin
            pix_load = 1'b1;
            if (in_roof) begin
               pix_in = ROOF_RGBA;
            end else if (in_floor) begin
               pix_in = FLOOR_RGBA;
            end else begin
               pix_in = BLACK_RGBA;
            end
         end
         S_RDIV_GO: begin
            // Offset times the texture side, left-aligned; 17 steps leave
            // the texture row in the low quotient bits.
            div_start = 1'b1;
            div_numer = {off_s[10:0], 6'b000000, 21'd0};
            div_denom = DIV_W'(span_ff);
            div_steps = 6'd17;
         end
         S_SHADE: begin
            pix_load = 1'b1;
            pix_in   = flags_ff[0] ? rd_data_ff : shade_rgba(rd_data_ff);
         end
         S_OUT:   load_rsp = slot_free;
         default: req_ready = 1'b0;
      endcase
   end

   rcw_sdiv u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .steps (div_steps),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         hd_ff       <= req_hit_distance;
         vc_ff       <= req_view_cosine;
         tcol_in_ff  <= req_texel_column;
         flags_in_ff <= {req_texture_select, req_texture_present, req_wall_vertical};
         row_ff      <= req_pixel_row;
      end
      if (state_ff == S_MUL) begin
         perp_ff <= hd_ff * vc_ff;
      end
      if (state_ff == S_DEN) begin
         sat_ff   <= (perp_ff == 32'd0);
         denom_ff <= {den_prod, 1'b0};
         numer_ff <= {focal_ff, 16'd0, 1'b0} + {1'b0, den_prod};
      end
      if (pix_load) begin
         pix_ff <= pix_in;
      end
      if (load_rsp) begin
         rsp_data_ff <= pix_ff;
      end
   end

   // Texture store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (accept && req_kind == KIND_TEXEL) begin
         tex_mem[{req_texture_select, req_texel_address}] <= req_texel_rgba;
      end
      if (state_ff == S_READ) begin
         rd_data_ff <= tex_mem[{flags_ff[3:2], div_quot[5:0], texel_ff}];
      end
   end

   // Control, configuration and column state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         height_ff    <= 11'd600;
         focal_ff     <= 20'd102400;
         step_ff      <= 5'd1;
         span_ff      <= '0;
         top_ff       <= '0;
         bottom_ff    <= '0;
         texel_ff     <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_HEIGHT: height_ff <= csr_wdata[10:0];
               CSR_FOCAL:  focal_ff  <= csr_wdata;
               CSR_STEP:   step_ff   <= csr_wdata[4:0];
               default:    height_ff <= height_ff;
            endcase
         end
         if (state_ff == S_SPAN) begin
            if (sat_ff || div_quot[DIV_W-1:12] != '0 || span_prod > 17'(SPAN_MAX)) begin
               span_ff <= SPAN_MAX;
            end else begin
               span_ff <= span_prod[11:0];
            end
            texel_ff <= tcol_in_ff;
            flags_ff <= flags_in_ff;
         end
         if (state_ff == S_EDGE) begin
            top_ff    <= half_s - EDGE_W'({2'b00, span_ff[11:1]});
            bottom_ff <= half_s + EDGE_W'({2'b00, span_ff[11:1]});
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_rgba = rsp_data_ff;

   `ASSERT_IMPLIES(a_idle_div, clock, reset, state_ff == S_IDLE, !div_busy)
   `ASSERT_IMPLIES(a_span_max, clock, reset, 1'b1, span_ff <= SPAN_MAX)
   `ASSERT_IMPLIES(a_shade_tex, clock, reset, state_ff == S_SHADE, flags_ff[1])
   `ASSERT_NEXT(a_rsp_load, clock, reset, load_rsp, rsp_valid)

endmodule
`default_nettype wire

// File: rtl/rcw_sdiv.sv
// ----------------------------------------------------------------------------
// rcw_sdiv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rcw_sdiv
   import rcw_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] numer,
   input  wire logic [DIV_W-1:0] denom,
   input  wire logic [5:0]       steps,
   output logic                  busy,
   output logic [DIV_W-1:0]      quot
);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] num_ff, num_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [DIV_W-1:0] quot_ff, quot_in;
   logic [5:0]       count_ff, count_in;
   logic             busy_ff, busy_in;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;

   always_comb begin
      rem_in   = rem_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      trial    = {rem_ff, num_ff[DIV_W-1]};
      diff     = trial - {1'b0, den_ff};
      if (start) begin
         rem_in   = '0;
         num_in   = numer;
         den_in   = denom;
         quot_in  = '0;
         count_in = steps;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         num_in   = {num_ff[DIV_W-2:0], 1'b0};
         if (!diff[DIV_W]) begin
            rem_in  = diff[DIV_W-1:0];
            quot_in = {quot_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DIV_W-1:0];
            quot_in = {quot_ff[DIV_W-2:0], 1'b0};
         end
         count_in = count_ff - 6'd1;
         busy_in  = (count_ff != 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      quot_ff  <= quot_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wall column shader. The texel columns that the
// column words use are loaded first, then column, row and texel words run
// under several register settings and three idling patterns. A scoreboard
// predicts every pixel.
// ----------------------------------------------------------------------------
module tb_top;
   import rcw_pkg::*;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] hit_dist;
      logic [15:0] cosine;
      logic [5:0]  tcol;
      logic        vert;
      logic        present;
      logic [1:0]  sel;
      logic [9:0]  row;
      logic [11:0] taddr;
      logic [31:0] rgba;
   } shader_word_type;

   class pixel_scoreboard;
      bit [10:0] height;
      bit [19:0] focal;
      bit [4:0]  step;
      int        top_row;
      int        bottom_row;
      int        span;
      bit [5:0]  tex_col;
      bit        vert_wall;
      bit        has_tex;
      bit [1:0]  tex_sel;
      bit [31:0] texels [16384];
      bit [31:0] pixel_q [$];
      int        errors;

      function void clear();
         height = 600;
         focal = 102400;
         step = 1;
         top_row = 0;
         bottom_row = 0;
         span = 0;
         tex_col = 0;
         vert_wall = 0;
         has_tex = 0;
         tex_sel = 0;
         pixel_q.delete();
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [19:0] val);
         if (idx == CSR_HEIGHT) height = val[10:0];
         else if (idx == CSR_FOCAL) focal = val;
         else if (idx == CSR_STEP) step = val[4:0];
      endfunction

      function bit [31:0] darken(bit [31:0] c);
         bit [31:0] r;
         r = c;
         for (int i = 1; i < 4; i++)
            r[i*8 +: 8] = 8'((32'(c[i*8 +: 8]) * 4) / 5);
         return r;
      endfunction

      function bit [31:0] pixel_for(int row);
         int        off;
         int        trow;
         bit [13:0] idx;
         bit [31:0] c;
         if (row < top_row) return ROOF_RGBA;
         if (row >= bottom_row) return FLOOR_RGBA;
         if (!has_tex || span == 0) return BLACK_RGBA;
         off = row - top_row;
         trow = (off * 64) / span;
         if (trow > 63) trow = 63;
         idx = {tex_sel, 6'(trow), tex_col};
         c = texels[idx];
         return vert_wall ? c : darken(c);
      endfunction

      function void note_accepted(shader_word_type w);
         longint unsigned stp;
         longint unsigned perp;
         longint unsigned num;
         longint unsigned den;
         longint unsigned q;
         int              h;
         case (w.kind)
            KIND_COLUMN: begin
               stp = (step == 0) ? 1 : step;
               perp = longint'(w.hit_dist) * longint'(w.cosine);
               if (perp == 0) begin
                  span = 2048;
               end else begin
                  num = longint'(focal) << 16;
                  den = perp * stp;
                  q = (2 * num + den) / (2 * den);
                  span = (q * stp > 2048) ? 2048 : int'(q * stp);
               end
               h = (height > 1024) ? 1024 : height;
               top_row = h / 2 - span / 2;
               bottom_row = h / 2 + span / 2;
               tex_col = w.tcol;
               vert_wall = w.vert;
               has_tex = w.present;
               tex_sel = w.sel;
            end
            KIND_ROW: pixel_q.insert(pixel_q.size(), pixel_for(int'(w.row)));
            KIND_TEXEL: texels[{w.sel, w.taddr}] = w.rgba;
            default: ;
         endcase
      endfunction

      function void check_pixel(bit [31:0] got);
         bit [31:0] want;
         if (pixel_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected pixel word %h", got);
            return;
         end
         want = pixel_q.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("pixel mismatch: expected %h, got %h", want, got);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_HEIGHT;
   logic [19:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   shader_word_type req_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_pixel_rgba;
   int          send_idle;
   int          recv_idle;
   pixel_scoreboard sb;

   raycast_wall_column_shader_core u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_word.kind),
      .req_hit_distance    (req_word.hit_dist),
      .req_view_cosine     (req_word.cosine),
      .req_texel_column    (req_word.tcol),
      .req_wall_vertical   (req_word.vert),
      .req_texture_present (req_word.present),
      .req_texture_select  (req_word.sel),
      .req_pixel_row       (req_word.row),
      .req_texel_address   (req_word.taddr),
      .req_texel_rgba      (req_word.rgba),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pixel_rgba      (rsp_pixel_rgba)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_pixel(rsp_pixel_rgba);
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

   // Called right after an edge; returns right after the edge that took the word.
   task automatic send_word(shader_word_type w);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      sb.note_accepted(w);
   endtask

   task automatic drain(int settle);
      req_valid <= 1'b0;
      while (sb.pixel_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [19:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Column words only use texture 2 at texel column 5 or 63, which are preloaded.
   function automatic shader_word_type random_word(int rows);
      shader_word_type w;
      logic [127:0]    raw;
      int              pick;
      raw = {$urandom, $urandom, $urandom, $urandom};
      w = raw[$bits(shader_word_type)-1:0];
      pick = $urandom_range(99);
      if (pick < 25) begin
         w.kind = KIND_COLUMN;
         if ($urandom_range(9) < 8) begin
            w.hit_dist = 16'($urandom_range(64, 4096));
            w.cosine = 16'($urandom_range(40000, 65535));
            w.present = ($urandom_range(9) != 0);
         end
         w.sel = 2'd2;
         w.tcol = ($urandom_range(1) != 0) ? 6'd63 : 6'd5;
      end else if (pick < 85) begin
         w.kind = KIND_ROW;
         if ($urandom_range(9) != 0) w.row = 10'($urandom_range(rows - 1));
      end else if (pick < 96) begin
         w.kind = KIND_TEXEL;
      end else begin
         w.kind = 2'd3;
      end
      return w;
   endfunction

   task automatic directed_words();
      shader_word_type w;
      int              r [6];
      r = '{0, 150, 299, 300, 301, 1023};
      w = '0;
      w.kind = KIND_COLUMN;
      w.present = 1'b1;
      w.sel = 2'd2;
      w.tcol = 6'd5;
      send_word(w);
      w.kind = KIND_ROW;
      for (int i = 0; i < 6; i++) begin
         w.row = 10'(r[i]);
         send_word(w);
      end
      w = '1;
      w.kind = KIND_COLUMN;
      w.sel = 2'd2;
      send_word(w);
      for (int i = 0; i < 4; i++) begin
         w.kind = KIND_ROW;
         w.row = 10'(r[i + 1]);
         send_word(w);
      end
      w = '0;
      w.kind = KIND_COLUMN;
      w.hit_dist = 16'd512;
      w.cosine = 16'hFFFF;
      w.vert = 1'b1;
      w.present = 1'b1;
      w.sel = 2'd2;
      w.tcol = 6'd63;
      send_word(w);
      w.kind = KIND_ROW;
      w.row = 10'd300;
      send_word(w);
      w.kind = KIND_COLUMN;
      w.present = 1'b0;
      send_word(w);
      w.kind = KIND_ROW;
      send_word(w);
      w.kind = 2'd3;
      send_word(w);
      w.kind = KIND_TEXEL;
      w.taddr = 12'hFFF;
      w.rgba = 32'hFFFF_FFFF;
      w.sel = 2'd3;
      send_word(w);
      w.kind = KIND_ROW;
      w.row = 10'd0;
      send_word(w);
   endtask

   initial begin
      int heights [6];
      int focals [6];
      int steps [6];
      int rows;
      int cfg;
      shader_word_type w;
      heights = '{600, 2, 1024, 2047, 480, 37};
      focals  = '{102400, 1, 1048575, 40000, 300000, 2048};
      steps   = '{1, 16, 0, 31, 3, 7};
      sb = new();
      sb.clear();
      send_idle = 0;
      recv_idle = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Load every texel row of the two columns that column words select.
      w = '0;
      w.kind = KIND_TEXEL;
      w.sel = 2'd2;
      for (int i = 0; i < 128; i++) begin
         w.taddr = {i[5:0], (i[6] ? 6'd63 : 6'd5)};
         w.rgba = $urandom;
         send_word(w);
      end

      cfg = 0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 33 : (phase == 1) ? 49 : 0;
         recv_idle = (phase == 0) ? 49 : (phase == 1) ? 33 : 0;
         for (int s = 0; s < 2; s++) begin
            drain(60);
            write_reg(CSR_HEIGHT, 20'(heights[cfg]));
            write_reg(CSR_FOCAL, 20'(focals[cfg]));
            write_reg(CSR_STEP, 20'(steps[cfg]));
            cfg++;
            if (phase == 0 && s == 0) directed_words();
            rows = (sb.height > 1024) ? 1024 : sb.height;
            for (int i = 0; i < 125; i++) send_word(random_word(rows));
         end
      end

      drain(60);
      if (sb.errors == 0 && sb.pixel_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: raycast_wall_column_shader_core.f
+incdir+rtl
rtl/rcw_pkg.sv
rtl/rcw_sdiv.sv
rtl/raycast_wall_column_shader_core.sv
dv/tb_top.sv
